// ===== sv/kkr_pkg.sv =====
// package: constants, cell control types for the differencing residue core
`timescale 1ns / 1ps
package kkr_pkg;
    localparam int NUM_BUCKETS = 128;
    localparam int VALUE_W     = 40;
    localparam int LABEL_W     = 7;
    localparam int SUM_W       = 47;
    localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_DIFF,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     hit;
        logic     sort_lo;
        logic     sort_hi;
        logic     head;
    } cell_ctrl_t;
endpackage

// ===== sv/kkr_cell.sv =====
// one cell of the bucket chain: accumulate, compare-exchange sort, shift-insert
`timescale 1ns / 1ps
module kkr_cell
    import kkr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [VALUE_W-1:0] value,
    input  logic [SUM_W-1:0]   d,
    input  logic [SUM_W-1:0]   nb_up,
    input  logic [SUM_W-1:0]   nb_dn,
    input  logic [SUM_W-1:0]   nb_dn2,
    output logic [SUM_W-1:0]   q
);
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W:0]   add_s;

    assign add_s = {1'b0, sum_reg} + (SUM_W + 1)'(value);

    always_comb
    begin
        sum_next = sum_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                if (ctrl.hit)
                begin
                    sum_next = add_s[SUM_W] ? SUM_MAX : add_s[SUM_W-1:0];
                end
            end
            OP_SORT:
            begin
                if (ctrl.sort_lo && nb_dn > sum_reg)
                begin
                    sum_next = nb_dn;
                end
                else if (ctrl.sort_hi && nb_up < sum_reg)
                begin
                    sum_next = nb_up;
                end
            end
            OP_DIFF:
            begin
                // insert d into the list shifted up by two
                if (!ctrl.head && d > nb_dn)
                begin
                    sum_next = nb_dn;
                end
                else
                begin
                    sum_next = (d > nb_dn2) ? d : nb_dn2;
                end
            end
            OP_CLEAR: sum_next = '0;
            default:  sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign q = sum_reg;
endmodule

// ===== sv/karmarkar_karp_residue_core.sv =====
// top level: bucket cell chain with sort and differencing sequencer
//
//  channel | signals                          | direction
//  in      | in_valid in_stall value label last | into block
//  out     | out_valid out_stall residue       | out of block
//
// a transaction without last is added into the cell that its label selects
// a transaction with last is also added, then starts the odd-even sort and the
// shift-insert differencing of the cell chain
// the cells clear when the residue is captured; reset clears every cell
// in_stall is high from the last transaction until the residue is taken
`timescale 1ns / 1ps
module karmarkar_karp_residue_core
    import kkr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  logic [LABEL_W-1:0] label,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SUM_W-1:0]   residue
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_DIFF,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] residue_reg;

    logic [SUM_W-1:0] cell_v [NUM_BUCKETS];
    logic [SUM_W-1:0] d;
    logic             in_acc;
    logic             diff_done;
    cell_op_t         op;
    logic [31:0]      label_mod;

    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign d         = cell_v[0] - cell_v[1];
    assign diff_done = (cell_v[1] == '0);
    assign label_mod = 32'(label) % NUM_BUCKETS;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  op = in_acc ? OP_LOAD : OP_HOLD;
            S_SORT:  op = OP_SORT;
            S_DIFF:  op = diff_done ? OP_CLEAR : OP_DIFF;
            default: op = OP_HOLD;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUCKETS; gi++)
        begin : g_cell
            cell_ctrl_t       ctrl;
            logic [SUM_W-1:0] nb_up;
            logic [SUM_W-1:0] nb_dn;
            logic [SUM_W-1:0] nb_dn2;

            assign ctrl.op      = op;
            assign ctrl.hit     = (label_mod == gi);
            assign ctrl.sort_lo = ((gi % 2) == int'(cnt_reg[0])) && (gi + 1 < NUM_BUCKETS);
            assign ctrl.sort_hi = ((gi % 2) != int'(cnt_reg[0])) && (gi > 0);
            assign ctrl.head    = (gi == 0);

            if (gi > 0)
            begin : g_up
                assign nb_up = cell_v[gi-1];
            end
            else
            begin : g_up0
                assign nb_up = SUM_MAX;
            end
            if (gi + 1 < NUM_BUCKETS)
            begin : g_dn
                assign nb_dn = cell_v[gi+1];
            end
            else
            begin : g_dn0
                assign nb_dn = '0;
            end
            if (gi + 2 < NUM_BUCKETS)
            begin : g_dn2
                assign nb_dn2 = cell_v[gi+2];
            end
            else
            begin : g_dn20
                assign nb_dn2 = '0;
            end

            kkr_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .value  (value),
                .d      (d),
                .nb_up  (nb_up),
                .nb_dn  (nb_dn),
                .nb_dn2 (nb_dn2),
                .q      (cell_v[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            residue_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && last)
                    begin
                        state_reg <= S_SORT;
                        cnt_reg   <= '0;
                    end
                end
                S_SORT:
                begin
                    if (cnt_reg == CNT_W'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= S_DIFF;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_DIFF:
                begin
                    if (diff_done)
                    begin
                        residue_reg <= cell_v[0];
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign residue   = residue_reg;

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while residue pending");
    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |-> (cell_v[0] >= cell_v[1]))
        else $error("chain head not ordered during differencing");
    a_out_from_diff: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DIFF))
        else $error("residue presented without differencing");
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (cell_v[0] == '0))
        else $error("cells not cleared after residue capture");
endmodule

// ===== tb/sv/karmarkar_karp_residue_core_tb.sv =====
// testbench: differencing residue core with random sets checked against a built-in predictor
`timescale 1ns / 1ps
module karmarkar_karp_residue_core_tb;
    import kkr_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] val;
        logic [LABEL_W-1:0] lbl;
        logic               lst;
    } entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value = '0;
    logic [LABEL_W-1:0] label = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SUM_W-1:0]   residue;

    karmarkar_karp_residue_core dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .value(value), .label(label), .last(last), .out_valid(out_valid),
        .out_stall(out_stall), .residue(residue)
    );

    always #10 clk = ~clk;

    entry_t           pending_q[$];
    logic [SUM_W-1:0] residue_q[$];
    logic [SUM_W-1:0] sums[NUM_BUCKETS];
    int mismatches = 0;
    int sets_done = 0;
    int sent = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    logic acc_in = 1'b0;

    // differencing of the bucket store, clears it afterwards
    function automatic logic [SUM_W-1:0] residue_of_sums();
        int big;
        int nxt;
        logic [SUM_W-1:0] r;
        forever
        begin
            big = 0;
            for (int k = 1; k < NUM_BUCKETS; k++)
                if (sums[k] > sums[big]) big = k;
            nxt = -1;
            for (int k = 0; k < NUM_BUCKETS; k++)
                if (k != big && (nxt < 0 || sums[k] > sums[nxt])) nxt = k;
            if (sums[nxt] == 0) break;
            sums[big] = sums[big] - sums[nxt];
            sums[nxt] = '0;
        end
        r = sums[big];
        for (int k = 0; k < NUM_BUCKETS; k++) sums[k] = '0;
        return r;
    endfunction

    function automatic void predict(entry_t e);
        logic [SUM_W:0] s;
        s = {1'b0, sums[e.lbl]} + (SUM_W + 1)'(e.val);
        sums[e.lbl] = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
        if (e.lst) residue_q.push_back(residue_of_sums());
    endfunction

    function automatic void add(logic [VALUE_W-1:0] v, logic [LABEL_W-1:0] l, logic t);
        entry_t e;
        e.val = v; e.lbl = l; e.lst = t;
        pending_q.push_back(e);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_val();
        case ($urandom_range(0, 4))
            0: return VALUE_W'({$urandom, $urandom});
            1: return VALUE_W'($urandom_range(0, 50));
            2: return {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 3));
            default: return VALUE_W'($urandom) & {VALUE_W{1'b1}};
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || acc_in)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    value <= pending_q[0].val;
                    label <= pending_q[0].lbl;
                    last <= pending_q[0].lst;
                    void'(pending_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
        end
    end

    // monitor and input capture
    always @(posedge clk)
    begin
        entry_t e;
        acc_in <= in_valid && !in_stall;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                e.val = value; e.lbl = label; e.lst = last;
                predict(e);
                sent <= sent + 1;
            end
            if (out_valid && !out_stall)
            begin
                sets_done <= sets_done + 1;
                if (residue_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected residue %0d", residue);
                end
                else
                begin
                    if (residue !== residue_q[0])
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("residue mismatch: expected %0d actual %0d",
                                     residue_q[0], residue);
                    end
                    void'(residue_q.pop_front());
                end
            end
            if (idle_cycles > 5000)
            begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("[karmarkar_karp_residue_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        for (int k = 0; k < NUM_BUCKETS; k++) sums[k] = '0;
        // directed: empty-ish, extremes, saturation, ties, the highest label
        add('0, '0, 1'b1);
        add({VALUE_W{1'b1}}, {LABEL_W{1'b1}}, 1'b1);
        for (int i = 0; i < 6; i++) add({VALUE_W{1'b1}}, 7'd5, 1'b0);
        for (int i = 0; i < 127; i++) add({VALUE_W{1'b1}}, 7'd5, 1'b0);
        add({VALUE_W{1'b1}}, 7'd5, 1'b1);
        add(40'd7, 7'd1, 1'b0); add(40'd7, 7'd2, 1'b0); add(40'd7, 7'd3, 1'b1);
        add(40'd8, 7'd0, 1'b0); add(40'd7, 7'd1, 1'b0); add(40'd6, 7'd2, 1'b0);
        add(40'd5, 7'd3, 1'b0); add(40'd4, 7'd127, 1'b1);
        add(40'h55_5555_5555, 7'h55, 1'b0); add(40'haa_aaaa_aaaa, 7'h2a, 1'b1);
        // random sets, mostly small, a few spanning many buckets
        n = pending_q.size();
        while (n < 1100)
        begin
            int len;
            bit plain;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 140) : $urandom_range(1, 12);
            plain = $urandom_range(0, 1);
            for (int i = 0; i < len; i++)
                add(rand_val(), plain ? LABEL_W'(i) : LABEL_W'($urandom_range(0, 127)),
                    i == len - 1);
            n += len;
        end
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        wait (pending_q.size() == 0 && !in_valid);
        wait (residue_q.size() == 0);
        repeat (300) @(posedge clk);
        $display("ran %0d transactions in %0d sets, %0d mismatches", sent, sets_done, mismatches);
        if (mismatches == 0 && residue_q.size() == 0)
            $display("[karmarkar_karp_residue_core] OK");
        else
            $display("[karmarkar_karp_residue_core] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/kkr_pkg.sv
sv/kkr_cell.sv
sv/karmarkar_karp_residue_core.sv
tb/sv/karmarkar_karp_residue_core_tb.sv
